[design/cec_pkg.sv]
package cec_pkg;

    // Envelope layout
    localparam logic [63:0] ENV_BYTES = 64'd24;
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h57, 8'h53, 8'h54};  // "SWST"

    // Result status codes
    typedef logic [2:0] cec_status_t;
    localparam cec_status_t ST_OK       = 3'd0;
    localparam cec_status_t ST_INVALID  = 3'd1;
    localparam cec_status_t ST_LIMIT    = 3'd2;
    localparam cec_status_t ST_TRUNC    = 3'd3;
    localparam cec_status_t ST_MAGIC    = 3'd4;
    localparam cec_status_t ST_VERSION  = 3'd5;
    localparam cec_status_t ST_TRAILING = 3'd6;
    localparam cec_status_t ST_CHECKSUM = 3'd7;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 8;
    typedef logic [CFG_INDEX_BITS-1:0] cec_cfg_index_t;
    localparam cec_cfg_index_t CFG_MAX_BYTES = 8'd0;
    localparam cec_cfg_index_t CFG_PROTOCOL  = 8'd1;

    localparam logic [31:0] MAX_BYTES_RESET = 32'd65536;
    localparam logic [15:0] PROTOCOL_RESET  = 16'd1;

    typedef struct packed {
        logic [31:0] max_bytes;
        logic [15:0] protocol;
    } cec_cfg_t;

    // Envelope fields and hash of a finished buffer
    typedef struct packed {
        logic        magic_mismatch;
        logic [15:0] protocol;
        logic [15:0] reserved;
        logic [63:0] declared_length;
        logic [63:0] stored_checksum;
        logic [63:0] hash;
    } cec_frame_t;

    // One FNV-1a 64 step; prime 0x100000001B3 as shift-adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

[design/cec_ifs.sv]
interface cec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cec_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] payload_length;
    logic [63:0] payload_checksum;

    modport source (output valid, output status, output payload_length,
                    output payload_checksum, input ready);
    modport sink   (input valid, input status, input payload_length,
                    input payload_checksum, output ready);
endinterface

interface cec_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] value;

    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface

[design/cec_cfg_regs.sv]
module cec_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    cec_cfg_if.sink           cfg,
    output cec_pkg::cec_cfg_t cfg_q
);
    import cec_pkg::*;

    logic [31:0] max_bytes_reg;
    logic [15:0] protocol_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
            protocol_reg  <= PROTOCOL_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MAX_BYTES: max_bytes_reg <= cfg.value;
                CFG_PROTOCOL:  protocol_reg  <= cfg.value[15:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    assign cfg_q.max_bytes = max_bytes_reg;
    assign cfg_q.protocol  = protocol_reg;

endmodule

[design/cec_frame_tracker.sv]
module cec_frame_tracker #(
    parameter int COUNT_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    cec_byte_if.sink                bytes,
    input  logic                    snap_take,
    output logic                    snap_valid,
    output cec_pkg::cec_frame_t     snap,
    output logic [COUNT_BITS-1:0]   snap_total,
    output logic                    snap_ceiling
);
    import cec_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Empty buffer: no fields seen, hash at the offset basis
    localparam cec_frame_t FRAME_RESET = '{
        magic_mismatch:  1'b0,
        protocol:        16'd0,
        reserved:        16'd0,
        declared_length: 64'd0,
        stored_checksum: 64'd0,
        hash:            FNV_BASIS
    };

    logic [COUNT_BITS-1:0] pos_reg, pos_next;
    cec_frame_t            frame_reg, frame_next;

    logic                  snap_valid_reg;
    cec_frame_t            snap_reg;
    logic [COUNT_BITS-1:0] snap_total_reg;

    logic                  accept;
    logic                  in_env;
    logic [4:0]            lane;
    logic [COUNT_BITS-1:0] total;

    assign bytes.ready = !snap_valid_reg || snap_take;
    assign accept      = bytes.valid && bytes.ready;

    assign in_env = pos_reg < ENV_BYTES[COUNT_BITS-1:0];
    assign lane   = pos_reg[4:0];
    assign total  = (pos_reg != COUNT_MAX) ? pos_reg + 1'b1 : pos_reg;

    always_comb
    begin
        frame_next = frame_reg;
        if (in_env)
        begin
            case (lane) inside
                [5'd0:5'd3]:
                    if (bytes.data_byte != MAGIC[lane[1:0]])
                        frame_next.magic_mismatch = 1'b1;
                [5'd4:5'd5]:
                    frame_next.protocol[8*lane[0] +: 8] = bytes.data_byte;
                [5'd6:5'd7]:
                    frame_next.reserved[8*lane[0] +: 8] = bytes.data_byte;
                [5'd8:5'd15]:
                    frame_next.declared_length[8*lane[2:0] +: 8] = bytes.data_byte;
                default:
                    frame_next.stored_checksum[8*lane[2:0] +: 8] = bytes.data_byte;
            endcase
        end
        else
        begin
            frame_next.hash = fnv_step(frame_reg.hash, bytes.data_byte);
        end
        pos_next = total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg                   <= '0;
            frame_reg                 <= FRAME_RESET;
            snap_valid_reg            <= 1'b0;
        end
        else
        begin
            if (accept && bytes.last_byte)
            begin
                pos_reg        <= '0;
                frame_reg      <= FRAME_RESET;
                snap_valid_reg <= 1'b1;
            end
            else
            begin
                if (accept)
                begin
                    pos_reg   <= pos_next;
                    frame_reg <= frame_next;
                end
                if (snap_take)
                    snap_valid_reg <= 1'b0;
            end
        end
    end

    // Snapshot payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && bytes.last_byte)
        begin
            snap_reg       <= frame_next;
            snap_total_reg <= pos_next;
        end
    end

    assign snap_valid   = snap_valid_reg;
    assign snap         = snap_reg;
    assign snap_total   = snap_total_reg;
    assign snap_ceiling = snap_total_reg == COUNT_MAX;

endmodule

[design/cec_status_eval.sv]
module cec_status_eval #(
    parameter int COUNT_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cec_pkg::cec_cfg_t       cfg_q,
    input  logic                    snap_valid,
    input  cec_pkg::cec_frame_t     snap,
    input  logic [COUNT_BITS-1:0]   snap_total,
    input  logic                    snap_ceiling,
    output logic                    snap_take,
    cec_result_if.source            results
);
    import cec_pkg::*;

    logic        out_valid_reg;
    cec_status_t status_reg, status_next;
    logic [31:0] length_reg, length_next;
    logic [63:0] checksum_reg, checksum_next;

    logic [63:0] maxb;
    logic [63:0] tot;
    logic [63:0] payload_bytes;
    logic        early;

    assign snap_take = snap_valid && (!out_valid_reg || results.ready);

    assign maxb          = {32'd0, cfg_q.max_bytes};
    assign tot           = {{(64-COUNT_BITS){1'b0}}, snap_total};
    assign payload_bytes = tot - ENV_BYTES;

    always_comb
    begin
        early       = 1'b0;
        status_next = ST_OK;
        if (maxb < ENV_BYTES)
        begin
            status_next = ST_INVALID;
            early       = 1'b1;
        end
        else if (tot > maxb || snap_ceiling)
        begin
            status_next = ST_LIMIT;
            early       = 1'b1;
        end
        else if (tot < ENV_BYTES)
        begin
            status_next = ST_TRUNC;
            early       = 1'b1;
        end
        else if (snap.magic_mismatch)
            status_next = ST_MAGIC;
        else if (snap.declared_length > maxb - ENV_BYTES)
            status_next = ST_LIMIT;
        else if (snap.protocol != cfg_q.protocol)
            status_next = ST_VERSION;
        else if (snap.reserved != 16'd0)
            status_next = ST_INVALID;
        else if (snap.declared_length > payload_bytes)
            status_next = ST_TRUNC;
        else if (snap.declared_length < payload_bytes)
            status_next = ST_TRAILING;
        else if (snap.hash != snap.stored_checksum)
            status_next = ST_CHECKSUM;

        if (early)
        begin
            length_next   = 32'd0;
            checksum_next = 64'd0;
        end
        else
        begin
            length_next   = (snap.declared_length[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                   : snap.declared_length[31:0];
            checksum_next = snap.hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (snap_take)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            status_reg   <= status_next;
            length_reg   <= length_next;
            checksum_reg <= checksum_next;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.status           = status_reg;
    assign results.payload_length   = length_reg;
    assign results.payload_checksum = checksum_reg;

endmodule

[design/checkpoint_envelope_checker.sv]
// Checkpoint envelope checker.
// bytes:   byte stream of one encoded buffer per transaction run; last_byte
//          marks its final byte. A new byte is taken every cycle unless stalled.
// results: one transaction per buffer, issued for its final byte: status,
//          declared payload length (saturated to 32 bits) and the FNV-1a 64
//          hash of the bytes after the 24-byte envelope; both zero if size checks fail.
// cfg:     register writes (index 0 max_encoded_bytes, 1 expected_protocol);
//          always ready, write only while no buffer is in flight.
// Result path: the final byte is registered in the frame state/snapshot register,
//          then the checks are registered in the status register.
// Throughput: one byte per cycle unless stalled, set by the per-byte hash
//          update (xor plus shift-add constant multiply) fed back into its register.
// Stall: a finished result waits in the output register; bytes keep flowing
//          until a second final byte is held in the snapshot, then bytes.ready
//          drops until the receiver takes the waiting result.
// Reset: clears the byte counter, envelope fields, hash (to the offset
//          basis) and both valid flags; registers return to 65536 and 1.
module checkpoint_envelope_checker #(
    parameter int COUNT_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    cec_byte_if.sink      bytes,
    cec_result_if.source  results,
    cec_cfg_if.sink       cfg
);
    import cec_pkg::*;

    cec_cfg_t              cfg_q;
    cec_frame_t            snap;
    logic                  snap_valid;
    logic                  snap_take;
    logic [COUNT_BITS-1:0] snap_total;
    logic                  snap_ceiling;

    // Register file
    cec_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Envelope capture and running hash; snapshot on the final byte
    cec_frame_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .bytes        (bytes),
        .snap_take    (snap_take),
        .snap_valid   (snap_valid),
        .snap         (snap),
        .snap_total   (snap_total),
        .snap_ceiling (snap_ceiling)
    );

    // Ordered checks into the output register
    cec_status_eval #(
        .COUNT_BITS (COUNT_BITS)
    ) u_eval (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_q        (cfg_q),
        .snap_valid   (snap_valid),
        .snap         (snap),
        .snap_total   (snap_total),
        .snap_ceiling (snap_ceiling),
        .snap_take    (snap_take),
        .results      (results)
    );

endmodule

[design/cec_checker.sv]
module cec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_status,
    input logic [31:0] out_length,
    input logic [63:0] out_checksum
);
    // final bytes taken whose results are not yet delivered
    logic [1:0] pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 2'd0;
        else
            pending_reg <= pending_reg + 2'(in_valid && in_ready && in_last)
                                       - 2'(out_valid && out_ready);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_status) && $stable(out_length) && $stable(out_checksum))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0 && pending_reg != 2'd3)
        else $error("result without a final byte, or more than two in flight");

    a_ready_only_on_backup: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while the output side moves");

endmodule

bind checkpoint_envelope_checker cec_checker u_cec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (bytes.valid),
    .in_ready     (bytes.ready),
    .in_last      (bytes.last_byte),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_status   (results.status),
    .out_length   (results.payload_length),
    .out_checksum (results.payload_checksum)
);
